// File: sv/met_pkg.sv
// Shared types, constants and palette for the escape-time colouriser.
// Depends on nothing; every other file imports it.
package met_pkg;

    // Unrolled depth of the iteration chain and palette size
    localparam int ITER_LIMIT   = 32;
    localparam int PALETTE_SIZE = 16;
    localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_THR  = 2'd1;
    localparam logic [7:0] MAX_ITER_RST = 8'd20;
    localparam logic [3:0] ESC_THR_RST  = 4'd2;

    localparam logic [7:0] WHITE = 8'd255;

    localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
    localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } t_in_word;

    typedef struct packed {
        logic       in_set;
        logic [7:0] iterations;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_word;

    // Word handed from cell to cell
    typedef struct packed {
        logic               escaped;
        logic [7:0]         steps;
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic signed [31:0] z_real;
        logic signed [31:0] z_imag;
    } t_cell_word;

    typedef struct packed {
        logic [7:0] n;      // effective step count, 1..ITER_LIMIT
        logic [3:0] thr;    // escape threshold on |z|^2
    } t_iter_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] pal_red(input logic [PAL_IDX_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:  r = 8'd245;
            4'd1:  r = 8'd40;
            4'd2:  r = 8'd52;
            4'd3:  r = 8'd107;
            4'd4:  r = 8'd159;
            4'd5:  r = 8'd143;
            4'd6:  r = 8'd58;
            4'd7:  r = 8'd129;
            4'd8:  r = 8'd154;
            4'd9:  r = 8'd108;
            4'd10: r = 8'd154;
            4'd11: r = 8'd96;
            4'd12: r = 8'd61;
            4'd13: r = 8'd60;
            4'd14: r = 8'd14;
            4'd15: r = 8'd115;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pal_green(input logic [PAL_IDX_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:  r = 8'd85;
            4'd1:  r = 8'd50;
            4'd2:  r = 8'd147;
            4'd3:  r = 8'd249;
            4'd4:  r = 8'd244;
            4'd5:  r = 8'd25;
            4'd6:  r = 8'd19;
            4'd7:  r = 8'd196;
            4'd8:  r = 8'd230;
            4'd9:  r = 8'd61;
            4'd10: r = 8'd206;
            4'd11: r = 8'd38;
            4'd12: r = 8'd226;
            4'd13: r = 8'd98;
            4'd14: r = 8'd111;
            4'd15: r = 8'd40;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pal_blue(input logic [PAL_IDX_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:  r = 8'd15;
            4'd1:  r = 8'd191;
            4'd2:  r = 8'd46;
            4'd3:  r = 8'd107;
            4'd4:  r = 8'd23;
            4'd5:  r = 8'd83;
            4'd6:  r = 8'd32;
            4'd7:  r = 8'd231;
            4'd8:  r = 8'd126;
            4'd9:  r = 8'd4;
            4'd10: r = 8'd48;
            4'd11: r = 8'd34;
            4'd12: r = 8'd104;
            4'd13: r = 8'd209;
            4'd14: r = 8'd46;
            4'd15: r = 8'd90;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/met_cell.sv
// One cell of the iteration chain: squares z, tests the previous step for
// escape, forms the next z. Depends on met_pkg.
module met_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  met_pkg::t_cell_word i_word,
    input  logic [7:0]          i_step,
    input  met_pkg::t_iter_cfg  i_cfg,
    output logic                o_valid,
    output met_pkg::t_cell_word o_word
);
    import met_pkg::*;

    logic               r_a_valid;
    t_cell_word         r_a_word;
    logic signed [63:0] r_rr;
    logic signed [63:0] r_ii;
    logic signed [63:0] r_ri;
    logic               r_b_valid;
    t_cell_word         r_b_word;
    t_cell_word         n_b_word;

    logic [63:0]        w_mag;
    logic [63:0]        w_limit;
    logic               w_check;
    logic signed [63:0] w_diff;
    logic signed [37:0] w_sum_r;
    logic signed [37:0] w_sum_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage A: the three products of z
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_word <= i_word;
            r_rr     <= $signed(i_word.z_real) * $signed(i_word.z_real);
            r_ii     <= $signed(i_word.z_imag) * $signed(i_word.z_imag);
            r_ri     <= $signed(i_word.z_real) * $signed(i_word.z_imag);
            r_b_word <= n_b_word;
        end
    end

    // Stage B: |z|^2 of the incoming z decides step i_step; then z*z + c
    always_comb begin
        w_mag   = $unsigned(r_rr) + $unsigned(r_ii);
        w_limit = {4'b0, i_cfg.thr, 56'b0};
        w_check = !r_a_word.escaped && (i_step != 8'd0) && (i_step <= i_cfg.n);
        w_diff  = r_rr - r_ii;
        w_sum_r = 38'(w_diff >>> 28) + 38'($signed(r_a_word.c_real));
        w_sum_i = 38'(r_ri >>> 27) + 38'($signed(r_a_word.c_imag));

        n_b_word        = r_a_word;
        n_b_word.z_real = sat32(w_sum_r);
        n_b_word.z_imag = sat32(w_sum_i);
        if (w_check && (w_mag > w_limit)) begin
            n_b_word.escaped = 1'b1;
            n_b_word.steps   = i_step;
        end
    end

    assign o_valid = r_b_valid;
    assign o_word  = r_b_word;

endmodule

// File: sv/met_color.sv
// Result stage: picks white or a palette colour and holds the output word.
// Depends on met_pkg.
module met_color (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  met_pkg::t_cell_word i_word,
    input  logic [7:0]          i_n,
    output logic                o_valid,
    output met_pkg::t_out_word  o_word
);
    import met_pkg::*;

    logic                 r_valid;
    t_out_word            r_word;
    t_out_word            n_word;
    logic [PAL_IDX_W-1:0] w_idx;

    always_comb begin
        w_idx = i_word.steps[PAL_IDX_W-1:0];
        if (i_word.escaped) begin
            n_word.in_set     = 1'b0;
            n_word.iterations = i_word.steps;
            n_word.red        = pal_red(w_idx);
            n_word.green      = pal_green(w_idx);
            n_word.blue       = pal_blue(w_idx);
        end else begin
            n_word.in_set     = 1'b1;
            n_word.iterations = i_n;
            n_word.red        = WHITE;
            n_word.green      = WHITE;
            n_word.blue       = WHITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: sv/mandelbrot_escape_time_colorizer.sv
// Top level of the escape-time colouriser: config registers, cell chain and
// result stage. Depends on met_pkg, met_cell and met_color.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_word (t_in_word)
//  out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One point enters per cycle while o_in_stall is low; its result leaves through
// the chain of ITER_LIMIT+1 cells with two register stages each, then the output
// register. The last cell only tests the final step.
// Reset clears all valid bits and loads max_iterations 20, threshold 2.
// A stalled output word freezes the whole chain; o_in_stall follows it.
module mandelbrot_escape_time_colorizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  met_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output met_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import met_pkg::*;

    localparam int NCELLS = ITER_LIMIT + 1;

    logic [7:0] r_max_iter;
    logic [3:0] r_esc_thr;
    t_iter_cfg  w_cfg;
    logic       w_adv;

    logic       w_valid [NCELLS+1];
    t_cell_word w_word  [NCELLS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
            r_esc_thr  <= ESC_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_ITER: r_max_iter <= i_cfg_data;
                REG_ESC_THR:  r_esc_thr  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the step count to 1..ITER_LIMIT
    always_comb begin
        if (r_max_iter == 8'd0) begin
            w_cfg.n = 8'd1;
        end else if (9'(r_max_iter) > 9'(ITER_LIMIT)) begin
            w_cfg.n = 8'(ITER_LIMIT);
        end else begin
            w_cfg.n = r_max_iter;
        end
        w_cfg.thr = r_esc_thr;
    end

    // Advance whenever the output register is empty or being taken
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    always_comb begin
        w_valid[0]        = i_in_valid;
        w_word[0].escaped = 1'b0;
        w_word[0].steps   = 8'd0;
        w_word[0].c_real  = i_in_word.c_real;
        w_word[0].c_imag  = i_in_word.c_imag;
        w_word[0].z_real  = 32'sd0;
        w_word[0].z_imag  = 32'sd0;
    end

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        met_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_word  (w_word[g]),
            .i_step  (8'(g)),
            .i_cfg   (w_cfg),
            .o_valid (w_valid[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    met_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_valid[NCELLS]),
        .i_word  (w_word[NCELLS]),
        .i_n     (w_cfg.n),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output word waiting");

    a_bounded_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.in_set) |-> (o_out_word.iterations == w_cfg.n))
        else $error("bounded point reports wrong step count");

    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.in_set)
            |-> (o_out_word.iterations != 8'd0 && o_out_word.iterations <= w_cfg.n))
        else $error("escape step outside 1..N");

    a_white_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.in_set)
            |-> (o_out_word.red == WHITE && o_out_word.green == WHITE
                 && o_out_word.blue == WHITE))
        else $error("bounded point not white");

endmodule

// File: dv/mandelbrot_escape_time_colorizer_tb.sv
// Self-checking bench for the escape-time colouriser: directed and random points
// under several register settings, idle and stall patterns, each result checked in order.
// Depends on met_pkg and the mandelbrot_escape_time_colorizer top level.
module mandelbrot_escape_time_colorizer_tb;
    import met_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;
    localparam int DRAIN_GUARD = 80;
    localparam int SHOWN_ERRS  = 30;

    localparam int N_FIXED = 23;
    localparam logic [31:0] FIXED_RE [N_FIXED] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hE000_0000, 32'hF000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0400_0000,
        32'h04CC_CCCD, 32'hF400_0000, 32'h1000_0000, 32'hE800_0000, 32'hF000_0000,
        32'h0800_0000, 32'hFE66_6666, 32'hE400_0000, 32'h0000_0001, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'h0000_0000, 32'hF000_0000};
    localparam logic [31:0] FIXED_IM [N_FIXED] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0000, 32'h0000_0000, 32'h1000_0000, 32'hF000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0199_999A, 32'h0000_0000, 32'h0000_0000, 32'h1000_0000,
        32'h0800_0000, 32'h0A66_6666, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001};

    // Register settings per phase, extremes and the clipping cases among them
    localparam logic [7:0] PHASE_STEPS [PHASES] = '{8'd255, 8'd1, 8'd32, 8'd0,
                                                    8'd33, 8'd7, 8'd31, 8'd16};
    localparam logic [3:0] PHASE_THR [PHASES]   = '{4'd15, 4'd1, 4'd4, 4'd0,
                                                    4'd2, 4'd15, 4'd3, 4'd8};

    class pixel_ledger;
        t_out_word  pending_pixels[$];
        logic [7:0] max_steps;
        logic [3:0] esc_bound;
        logic [7:0] red_lut[16];
        logic [7:0] green_lut[16];
        logic [7:0] blue_lut[16];
        int         errors;

        function new();
            max_steps = MAX_ITER_RST;
            esc_bound = ESC_THR_RST;
            errors    = 0;
            red_lut   = '{245, 40, 52, 107, 159, 143, 58, 129,
                          154, 108, 154, 96, 61, 60, 14, 115};
            green_lut = '{85, 50, 147, 249, 244, 25, 19, 196,
                          230, 61, 206, 38, 226, 98, 111, 40};
            blue_lut  = '{15, 191, 46, 107, 23, 83, 32, 231,
                          126, 4, 48, 34, 104, 209, 46, 90};
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == REG_MAX_ITER) begin
                max_steps = data;
            end else if (idx == REG_ESC_THR) begin
                esc_bound = data[3:0];
            end
        endfunction

        function logic signed [63:0] clip32(logic signed [63:0] v);
            logic signed [63:0] r;
            r = v;
            if (v > 64'sd2147483647) begin
                r = 64'sd2147483647;
            end else if (v < -64'sd2147483648) begin
                r = -64'sd2147483648;
            end
            return r;
        endfunction

        function t_out_word escape_pixel(t_in_word p);
            logic signed [63:0] cr, ci, zr, zi, rr, ii, ri;
            logic [63:0] mag, bound, sq_r, sq_i;
            logic [7:0] n, steps;
            logic       escaped;
            t_out_word  r;
            cr = {{32{p.c_real[31]}}, p.c_real};
            ci = {{32{p.c_imag[31]}}, p.c_imag};
            zr = '0;
            zi = '0;
            bound = {60'd0, esc_bound} << 56;
            n = max_steps;
            if (n == 8'd0) n = 8'd1;
            if (n > ITER_LIMIT) n = 8'(ITER_LIMIT);
            steps = 8'd0;
            escaped = 1'b0;
            for (int k = 1; k <= n && !escaped; k++) begin
                rr = zr * zr;
                ii = zi * zi;
                ri = zr * zi;
                // arithmetic shift gives the floor for negative values
                zr = clip32(((rr - ii) >>> 28) + cr);
                zi = clip32((ri >>> 27) + ci);
                sq_r = zr * zr;
                sq_i = zi * zi;
                mag = sq_r + sq_i;
                steps = 8'(k);
                if (mag > bound) escaped = 1'b1;
            end
            if (escaped) begin
                r.in_set     = 1'b0;
                r.iterations = steps;
                r.red        = red_lut[steps[3:0]];
                r.green      = green_lut[steps[3:0]];
                r.blue       = blue_lut[steps[3:0]];
            end else begin
                r.in_set     = 1'b1;
                r.iterations = n;
                r.red        = WHITE;
                r.green      = WHITE;
                r.blue       = WHITE;
            end
            return r;
        endfunction

        function void note_point(t_in_word p);
            pending_pixels.push_back(escape_pixel(p));
        endfunction

        function void flag(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= SHOWN_ERRS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_pixel(t_out_word got);
            t_out_word want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRS)
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, got);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.in_set !== want.in_set)         flag("in_set", want.in_set, got.in_set);
            if (got.iterations !== want.iterations) flag("iterations", want.iterations,
                                                         got.iterations);
            if (got.red !== want.red)               flag("red", want.red, got.red);
            if (got.green !== want.green)           flag("green", want.green, got.green);
            if (got.blue !== want.blue)             flag("blue", want.blue, got.blue);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    int idle_pct  = 0;
    int stall_pct = 0;

    pixel_ledger ledger = new();

    mandelbrot_escape_time_colorizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ledger.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) ledger.note_point(i_in_word);
            if (o_out_valid && !i_out_stall) ledger.check_pixel(o_out_word);
        end
    end

    // Hold the word until accepted, then idle at random
    task automatic put_point(input t_in_word p);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= p;
        do @(posedge i_clk); while (o_in_stall);
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending_pixels.size() != 0);
    endtask

    function automatic t_in_word random_point();
        t_in_word p;
        if ($urandom_range(0, 9) < 2) begin
            p.c_real = $urandom;
            p.c_imag = $urandom;
        end else begin
            // real in [-2.5, 1.0], imaginary in [-1.5, 1.5]
            p.c_real = $urandom_range(0, 32'h3800_0000) - 32'h2800_0000;
            p.c_imag = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
        end
        return p;
    endfunction

    initial begin
        t_in_word p;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, no idling
        for (int i = 0; i < N_FIXED; i++) begin
            p.c_real = FIXED_RE[i];
            p.c_imag = FIXED_IM[i];
            put_point(p);
        end
        drain_pixels();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            write_reg(REG_MAX_ITER, PHASE_STEPS[ph]);
            write_reg(REG_ESC_THR, {4'($urandom), PHASE_THR[ph]});
            if (ph == 3) write_reg(REG_SPARE, 8'($urandom));
            i_cfg_valid <= 1'b0;

            p.c_real = '0;
            p.c_imag = '0;
            put_point(p);
            p.c_real = 32'h0400_0000;
            put_point(p);
            repeat (PHASE_ITEMS) put_point(random_point());
            drain_pixels();
        end

        repeat (DRAIN_GUARD) @(posedge i_clk);
        if (ledger.pending_pixels.size() != 0) begin
            ledger.errors++;
            $display("%0t: results still outstanding, expected 0, got %0d",
                     $time, ledger.pending_pixels.size());
        end
        if (ledger.errors == 0) begin
            $display("mandelbrot_escape_time_colorizer_tb: clean");
        end else begin
            $display("mandelbrot_escape_time_colorizer_tb: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("mandelbrot_escape_time_colorizer_tb: errors");
        $finish;
    end

endmodule

// File: files.f
sv/met_pkg.sv
sv/met_cell.sv
sv/met_color.sv
sv/mandelbrot_escape_time_colorizer.sv
dv/mandelbrot_escape_time_colorizer_tb.sv
